// ----- sv/iol_pkg.sv -----
// iol_pkg: shared constants, codes and control types for the indexed ordered list
// used by iol_ctrl, iol_cell and indexed_ordered_list; depends on nothing
package iol_pkg;

  localparam int CAPACITY = 16;

  // fixed field widths of the words on the ports
  localparam int ACTION_W = 3;
  localparam int POS_W    = 5;
  localparam int DATA_W   = 32;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;

  // widths that follow from the capacity
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [ACTION_W-1:0] {
    ACT_READ       = 3'd0,
    ACT_PUSH_FRONT = 3'd1,
    ACT_PUSH_BACK  = 3'd2,
    ACT_INSERT     = 3'd3,
    ACT_REMOVE     = 3'd4,
    ACT_POP_FRONT  = 3'd5,
    ACT_POP_BACK   = 3'd6,
    ACT_CLEAR      = 3'd7
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,
    CELL_REM  = 2'd2
  } cell_op_e;

  // broadcast to every cell of the row
  typedef struct packed {
    cell_op_e                  op;
    logic [CMP_W-1:0]          pos;
    logic signed [DATA_W-1:0]  value;
  } cell_ctl_t;

  // outcome of one word, handed to the result register
  typedef struct packed {
    status_e           status;
    logic [CNT_W-1:0]  count;
    logic              rd_en;
  } res_t;

endpackage

// ----- sv/iol_cell.sv -----
// iol_cell: one slot of the list, shifts toward or away from the front
// depends on iol_pkg
module iol_cell (
  input  logic                              clk_i,
  input  logic [iol_pkg::IDX_W-1:0]         idx_i,
  input  logic signed [iol_pkg::DATA_W-1:0] left_i,
  input  logic signed [iol_pkg::DATA_W-1:0] right_i,
  input  iol_pkg::cell_ctl_t                ctl_i,
  output logic signed [iol_pkg::DATA_W-1:0] value_o,
  output logic [iol_pkg::DATA_W-1:0]        tap_o
);

  logic signed [iol_pkg::DATA_W-1:0] value_q, value_d;
  logic [iol_pkg::CMP_W-1:0]         idx_ext;

  assign idx_ext = iol_pkg::CMP_W'(idx_i);

  always_comb begin
    value_d = value_q;
    case (ctl_i.op)
      iol_pkg::CELL_INS: begin
        if (idx_ext > ctl_i.pos) begin
          value_d = left_i;
        end else if (idx_ext == ctl_i.pos) begin
          value_d = ctl_i.value;
        end
      end
      iol_pkg::CELL_REM: begin
        if (idx_ext >= ctl_i.pos) begin
          value_d = right_i;
        end
      end
      default: value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  // contributes to the read bus only when addressed
  assign tap_o   = (idx_ext == ctl_i.pos) ? value_q : '0;

endmodule

// ----- sv/iol_ctrl.sv -----
// iol_ctrl: action decode, range checks and the entry count register
// depends on iol_pkg
module iol_ctrl (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              fire_i,
  input  logic [iol_pkg::ACTION_W-1:0]      action_i,
  input  logic [iol_pkg::POS_W-1:0]         position_i,
  input  logic signed [iol_pkg::DATA_W-1:0] value_i,
  output iol_pkg::cell_ctl_t                ctl_o,
  output iol_pkg::res_t                     res_o
);

  logic [iol_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic [iol_pkg::CMP_W-1:0] pos_ext, cnt_ext;
  logic                      empty, full;
  iol_pkg::cell_op_e         op;
  logic [iol_pkg::CMP_W-1:0] eff_pos;
  iol_pkg::status_e          status;
  logic                      rd_en;
  logic                      clear;

  assign pos_ext = iol_pkg::CMP_W'(position_i);
  assign cnt_ext = iol_pkg::CMP_W'(cnt_q);
  assign empty   = (cnt_q == '0);
  assign full    = (cnt_q == iol_pkg::CNT_W'(iol_pkg::CAPACITY));

  always_comb begin
    op      = iol_pkg::CELL_HOLD;
    eff_pos = pos_ext;
    status  = iol_pkg::ST_OK;
    rd_en   = 1'b0;
    clear   = 1'b0;
    case (iol_pkg::action_e'(action_i))
      iol_pkg::ACT_READ, iol_pkg::ACT_REMOVE: begin
        if (empty) begin
          status = iol_pkg::ST_EMPTY;
        end else if (pos_ext >= cnt_ext) begin
          status = iol_pkg::ST_RANGE;
        end else begin
          rd_en = 1'b1;
          if (iol_pkg::action_e'(action_i) == iol_pkg::ACT_REMOVE) begin
            op = iol_pkg::CELL_REM;
          end
        end
      end
      iol_pkg::ACT_PUSH_FRONT: begin
        eff_pos = '0;
        if (full) status = iol_pkg::ST_FULL;
        else op = iol_pkg::CELL_INS;
      end
      iol_pkg::ACT_PUSH_BACK: begin
        eff_pos = cnt_ext;
        if (full) status = iol_pkg::ST_FULL;
        else op = iol_pkg::CELL_INS;
      end
      iol_pkg::ACT_INSERT: begin
        if (full) status = iol_pkg::ST_FULL;
        else if (pos_ext > cnt_ext) status = iol_pkg::ST_RANGE;
        else op = iol_pkg::CELL_INS;
      end
      iol_pkg::ACT_POP_FRONT, iol_pkg::ACT_POP_BACK: begin
        eff_pos = (iol_pkg::action_e'(action_i) == iol_pkg::ACT_POP_FRONT) ?
                  '0 : (cnt_ext - iol_pkg::CMP_W'(1));
        if (empty) begin
          status = iol_pkg::ST_EMPTY;
        end else begin
          op    = iol_pkg::CELL_REM;
          rd_en = 1'b1;
        end
      end
      iol_pkg::ACT_CLEAR: clear = 1'b1;
      default: clear = 1'b0;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    if (clear) begin
      cnt_d = '0;
    end else if (op == iol_pkg::CELL_INS) begin
      cnt_d = cnt_q + iol_pkg::CNT_W'(1);
    end else if (op == iol_pkg::CELL_REM) begin
      cnt_d = cnt_q - iol_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (fire_i) begin
      cnt_q <= cnt_d;
    end
  end

  assign ctl_o.op     = fire_i ? op : iol_pkg::CELL_HOLD;
  assign ctl_o.pos    = eff_pos;
  assign ctl_o.value  = value_i;
  assign res_o.status = status;
  assign res_o.count  = cnt_d;
  assign res_o.rd_en  = rd_en;

endmodule

// ----- sv/indexed_ordered_list.sv -----
// indexed_ordered_list: top level, a row of slot cells with a result register
// depends on iol_pkg, iol_ctrl and iol_cell
//
// usage
//   input channel: in_valid_i / in_stall_o carry one word per accepted edge:
//     action, position and value. output channel: out_valid_o / out_stall_i
//     carry one result word per input word: read value, count after the
//     action, and status (ok, position out of range, full, empty).
//   result: the result word is registered and is valid in the cycle after its
//     input word is accepted.
//   throughput: one word per cycle unless the input is stalled. every slot
//     cell compares its index with the effective position and shifts left or
//     right in the same cycle, so a whole-row insert or remove is done at once.
//   stall: the single result register holds while out_stall_i is high; the
//     input is stalled only when that register is full and stalled, so a new
//     word is taken in the same cycle a waiting result is taken.
//   reset: rst_ni clears the entry count and the result valid flag; slot
//     contents are left as they are and are never read before written.
//   failed actions leave the list as it was and return a read value of zero.
module indexed_ordered_list (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [iol_pkg::ACTION_W-1:0]        in_action_i,
  input  logic [iol_pkg::POS_W-1:0]           in_position_i,
  input  logic signed [iol_pkg::DATA_W-1:0]   in_value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [iol_pkg::DATA_W-1:0]   out_read_value_o,
  output logic [iol_pkg::COUNT_W-1:0]         out_count_o,
  output logic [iol_pkg::STATUS_W-1:0]        out_status_o
);

  logic                               fire;
  iol_pkg::cell_ctl_t                 ctl;
  iol_pkg::res_t                      res;
  logic signed [iol_pkg::DATA_W-1:0]  slot_val [iol_pkg::CAPACITY];
  logic [iol_pkg::DATA_W-1:0]         slot_tap [iol_pkg::CAPACITY];
  logic [iol_pkg::DATA_W-1:0]         rd_bus;

  logic                               out_valid_q;
  logic signed [iol_pkg::DATA_W-1:0]  rd_q;
  logic [iol_pkg::COUNT_W-1:0]        count_q;
  logic [iol_pkg::STATUS_W-1:0]       status_q;

  // the input is held off only while a result is waiting and stalled
  assign in_stall_o = out_valid_q & out_stall_i;
  assign fire       = in_valid_i & ~in_stall_o;

  iol_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .action_i   (in_action_i),
    .position_i (in_position_i),
    .value_i    (in_value_i),
    .ctl_o      (ctl),
    .res_o      (res)
  );

  // row of slot cells, front of the list at index zero
  for (genvar g = 0; g < iol_pkg::CAPACITY; g++) begin : g_cell
    logic signed [iol_pkg::DATA_W-1:0] left, right;
    // the end cells feed back their own value; that edge never matters
    assign left  = (g == 0) ? slot_val[g] : slot_val[(g == 0) ? 0 : g - 1];
    assign right = (g == iol_pkg::CAPACITY - 1) ? slot_val[g] :
                   slot_val[(g == iol_pkg::CAPACITY - 1) ? g : g + 1];
    iol_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (iol_pkg::IDX_W'(g)),
      .left_i  (left),
      .right_i (right),
      .ctl_i   (ctl),
      .value_o (slot_val[g]),
      .tap_o   (slot_tap[g])
    );
  end

  // at most one cell is addressed, so an or of the taps picks it
  always_comb begin
    rd_bus = '0;
    for (int i = 0; i < iol_pkg::CAPACITY; i++) begin
      rd_bus = rd_bus | slot_tap[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      rd_q     <= res.rd_en ? $signed(rd_bus) : '0;
      count_q  <= iol_pkg::COUNT_W'(res.count);
      status_q <= res.status;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_read_value_o = rd_q;
  assign out_count_o      = count_q;
  assign out_status_o     = status_q;

`ifndef ASSERT_OFF
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_count_o <= iol_pkg::COUNT_W'(iol_pkg::CAPACITY)))
    else $error("count above capacity");

  a_full_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_status_o == iol_pkg::ST_FULL) |->
    (out_count_o == iol_pkg::COUNT_W'(iol_pkg::CAPACITY)))
    else $error("full status with list not full");

  a_empty_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_status_o == iol_pkg::ST_EMPTY) |-> (out_count_o == '0))
    else $error("empty status with entries present");

  a_fail_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_status_o != iol_pkg::ST_OK) |-> (out_read_value_o == '0))
    else $error("failed action returned nonzero value");
`endif

endmodule

// ----- tb/sv/iol_checker.sv -----
`timescale 1ns / 1ps
// iol_checker: watches both channels of indexed_ordered_list, predicts each result word
// from its own copy of the list and compares field by field; depends on iol_pkg
module iol_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_stall_i,
  input  logic [iol_pkg::ACTION_W-1:0]        in_action_i,
  input  logic [iol_pkg::POS_W-1:0]           in_position_i,
  input  logic signed [iol_pkg::DATA_W-1:0]   in_value_i,
  input  logic                                out_valid_i,
  input  logic                                out_stall_i,
  input  logic signed [iol_pkg::DATA_W-1:0]   out_read_value_i,
  input  logic [iol_pkg::COUNT_W-1:0]         out_count_i,
  input  logic [iol_pkg::STATUS_W-1:0]        out_status_i,
  output int                                  errors_o,
  output int                                  pending_o,
  output int                                  fill_o,
  output int                                  results_o,
  output int                                  full_hits_o,
  output int                                  empty_hits_o,
  output int                                  range_hits_o
);
  import iol_pkg::*;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic [COUNT_W-1:0]       count;
    status_e                  status;
  } list_res_t;

  logic signed [DATA_W-1:0] slot_q [CAPACITY];
  int                       fill;
  list_res_t                awaited_q [$];
  list_res_t                want;

  task automatic report_mismatch(input string what, input longint want_v, input longint got_v);
    $display("mismatch at %0t ns: %s, expected %0d, got %0d", $time, what, want_v, got_v);
    errors_o++;
  endtask

  // shift entries from position at onward one place back, then write the new entry
  function automatic void open_slot(input int at, input logic signed [DATA_W-1:0] val);
    for (int i = fill; i > at; i--) slot_q[i] = slot_q[i-1];
    slot_q[at] = val;
    fill++;
  endfunction

  // close the gap left by the entry at position at
  function automatic void drop_slot(input int at);
    for (int i = at; i + 1 < fill; i++) slot_q[i] = slot_q[i+1];
    fill--;
  endfunction

  // apply one word to the list copy and return the result word it causes
  function automatic list_res_t list_apply(input action_e act, input logic [POS_W-1:0] pos,
                                           input logic signed [DATA_W-1:0] val);
    list_res_t r;
    int        at;
    r.read_value = '0;
    r.status     = ST_OK;
    at           = 0;
    case (act)
      ACT_READ, ACT_REMOVE: begin
        // empty check wins over the position check
        if (fill == 0) r.status = ST_EMPTY;
        else if (int'(pos) >= fill) r.status = ST_RANGE;
        else begin
          r.read_value = slot_q[pos];
          if (act == ACT_REMOVE) drop_slot(int'(pos));
        end
      end
      ACT_PUSH_FRONT, ACT_PUSH_BACK, ACT_INSERT: begin
        // full check wins over the position check
        if (fill >= CAPACITY) r.status = ST_FULL;
        else if (act == ACT_INSERT && int'(pos) > fill) r.status = ST_RANGE;
        else begin
          at = (act == ACT_PUSH_FRONT) ? 0 : (act == ACT_PUSH_BACK) ? fill : int'(pos);
          open_slot(at, val);
        end
      end
      ACT_POP_FRONT, ACT_POP_BACK: begin
        if (fill == 0) r.status = ST_EMPTY;
        else begin
          at = (act == ACT_POP_FRONT) ? 0 : fill - 1;
          r.read_value = slot_q[at];
          drop_slot(at);
        end
      end
      default: fill = 0;
    endcase
    r.count = COUNT_W'(fill);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill = 0;
      awaited_q.delete();
    end else begin
      // results first: a result never belongs to the word taken at the same edge
      if (out_valid_i && !out_stall_i) begin
        results_o++;
        if (awaited_q.size() == 0) begin
          report_mismatch("result word with none awaited, count", 0, out_count_i);
        end else begin
          want = awaited_q[0];
          awaited_q.delete(0);
          if (out_read_value_i !== want.read_value)
            report_mismatch("read_value", want.read_value, out_read_value_i);
          if (out_count_i !== want.count)
            report_mismatch("count", want.count, out_count_i);
          if (out_status_i !== want.status)
            report_mismatch("status", want.status, out_status_i);
          case (want.status)
            ST_FULL:  full_hits_o++;
            ST_EMPTY: empty_hits_o++;
            ST_RANGE: range_hits_o++;
            default: ;
          endcase
        end
      end
      if (in_valid_i && !in_stall_i)
        awaited_q.insert(awaited_q.size(),
                         list_apply(action_e'(in_action_i), in_position_i, in_value_i));
    end
    pending_o = awaited_q.size();
    fill_o    = fill;
  end

endmodule

// ----- tb/sv/tb_indexed_ordered_list.sv -----
`timescale 1ns / 1ps
// tb_indexed_ordered_list: drives action words into indexed_ordered_list with random
// gaps and output stalls; depends on iol_pkg, indexed_ordered_list and iol_checker
module tb_indexed_ordered_list;
  import iol_pkg::*;

  typedef enum int {MODE_GROW, MODE_SHRINK, MODE_MIXED, MODE_NOISE} mode_e;

  localparam int WORDS_TARGET = 1250;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [ACTION_W-1:0]      in_action = '0;
  logic [POS_W-1:0]         in_position = '0;
  logic signed [DATA_W-1:0] in_value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] out_read_value;
  logic [COUNT_W-1:0]       out_count;
  logic [STATUS_W-1:0]      out_status;

  int errors, pending, fill, results, full_hits, empty_hits, range_hits;
  int words_sent;
  bit quiet;
  int stall_run, calm_run, roll;
  logic stall_nxt;

  always #5 clk = ~clk;

  indexed_ordered_list u_top (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .in_action_i      (in_action),
    .in_position_i    (in_position),
    .in_value_i       (in_value),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .out_read_value_o (out_read_value),
    .out_count_o      (out_count),
    .out_status_o     (out_status)
  );

  iol_checker u_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_action_i      (in_action),
    .in_position_i    (in_position),
    .in_value_i       (in_value),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_read_value_i (out_read_value),
    .out_count_i      (out_count),
    .out_status_i     (out_status),
    .errors_o         (errors),
    .pending_o        (pending),
    .fill_o           (fill),
    .results_o        (results),
    .full_hits_o      (full_hits),
    .empty_hits_o     (empty_hits),
    .range_hits_o     (range_hits)
  );

  // receiver back-pressure: calm stretches, short stalls and a few long ones
  always @(negedge clk) begin
    if (calm_run > 0) begin
      calm_run--;
      stall_nxt = 1'b0;
    end else if (stall_run > 0) begin
      stall_run--;
      stall_nxt = 1'b1;
    end else begin
      roll = $urandom_range(0, 99);
      stall_nxt = 1'b0;
      if (roll < 4) calm_run = $urandom_range(30, 150);
      else if (roll >= 70) begin
        stall_nxt = 1'b1;
        stall_run = (roll < 94) ? $urandom_range(0, 2) : $urandom_range(8, 40);
      end
    end
    out_stall <= stall_nxt;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic action_e pick_action(input mode_e mode);
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) return ACT_CLEAR;
    case (mode)
      MODE_GROW:
        if (r < 72) begin
          case ($urandom_range(0, 2))
            0:       return ACT_PUSH_FRONT;
            1:       return ACT_PUSH_BACK;
            default: return ACT_INSERT;
          endcase
        end
      MODE_SHRINK:
        if (r < 72) begin
          case ($urandom_range(0, 3))
            0:       return ACT_REMOVE;
            1:       return ACT_POP_FRONT;
            2:       return ACT_POP_BACK;
            default: return ACT_READ;
          endcase
        end
      MODE_NOISE: return action_e'($urandom_range(0, 7));
      default: ;
    endcase
    return action_e'($urandom_range(0, 6));
  endfunction

  // positions mostly inside the list, some on the edge, some anywhere in the field
  function automatic logic [POS_W-1:0] pick_position(input mode_e mode);
    int r;
    int p;
    r = $urandom_range(0, 99);
    if (mode == MODE_NOISE || r < 8) return POS_W'($urandom_range(0, 31));
    if (r < 18) begin
      p = fill + $urandom_range(0, 2);
      return POS_W'((p > 31) ? 31 : p);
    end
    return POS_W'($urandom_range(0, fill));
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)  return 32'sh7fff_ffff;
    if (r < 16) return 32'sh8000_0000;
    if (r < 22) return 32'sh0;
    if (r < 28) return -32'sd1;
    return $urandom;
  endfunction

  // present one word after an optional gap and hold it until taken
  task automatic send_word(input action_e act, input logic [POS_W-1:0] pos,
                           input logic signed [DATA_W-1:0] val);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    in_action   <= act;
    in_position <= pos;
    in_value    <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    mode_e mode;
    int    len;
    int    waited;
    action_e act;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty list, range edges, extreme values
    send_word(ACT_CLEAR, 5'd0, 32'sh0);
    send_word(ACT_READ, 5'd0, 32'sh0);
    send_word(ACT_REMOVE, 5'd0, 32'sh0);
    send_word(ACT_POP_FRONT, 5'd0, 32'sh0);
    send_word(ACT_POP_BACK, 5'd31, 32'sh0);
    send_word(ACT_INSERT, 5'd1, 32'sd5);
    send_word(ACT_INSERT, 5'd31, 32'sd6);
    send_word(ACT_PUSH_FRONT, 5'd31, 32'sh7fff_ffff);
    send_word(ACT_PUSH_BACK, 5'd0, 32'sh8000_0000);
    send_word(ACT_INSERT, 5'd2, -32'sd1);
    send_word(ACT_INSERT, 5'd1, 32'sh0);
    send_word(ACT_INSERT, 5'd5, 32'sd7);
    send_word(ACT_READ, 5'd3, 32'sh0);
    send_word(ACT_READ, 5'd4, 32'sh0);
    send_word(ACT_READ, 5'd31, 32'sh0);
    send_word(ACT_REMOVE, 5'd31, 32'sh0);
    send_word(ACT_REMOVE, 5'd1, 32'sh0);
    send_word(ACT_POP_FRONT, 5'd0, 32'sh0);
    send_word(ACT_POP_BACK, 5'd0, 32'sh0);
    send_word(ACT_READ, 5'd0, 32'sh0);
    send_word(ACT_CLEAR, 5'd0, 32'sh0);
    send_word(ACT_REMOVE, 5'd16, 32'sh0);

    // random phases: grow toward full, drain toward empty, mixed and noise
    mode = MODE_GROW;
    while (words_sent < WORDS_TARGET) begin
      len   = $urandom_range(20, 60);
      quiet = ($urandom_range(0, 4) == 0);
      for (int k = 0; k < len; k++) begin
        act = pick_action(mode);
        send_word(act, pick_position(mode), pick_value());
      end
      mode = mode_e'($urandom_range(0, 9) < 8 ? $urandom_range(0, 2) : MODE_NOISE);
    end
    @(negedge clk);
    in_valid <= 1'b0;

    waited = 0;
    while (pending != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);

    $display("summary: %0d words sent, %0d result words checked", words_sent, results);
    $display("summary: rejected words - full %0d, empty %0d, position %0d",
             full_hits, empty_hits, range_hits);
    if (pending != 0)
      $display("%0d result words never arrived", pending);
    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
